// ----- rtl/crc8cmd_pkg.sv -----
`timescale 1ns / 1ps

package crc8cmd_pkg;

  // Frame buffer geometry.
  localparam int unsigned FRAME_DEPTH = 16;
  localparam int unsigned FRAME_AW    = $clog2(FRAME_DEPTH);
  localparam int unsigned FRAME_LW    = $clog2(FRAME_DEPTH + 1);

  // Reply and retry limits.
  localparam int unsigned REPLY_MAX    = 64;
  localparam int unsigned REPLY_W      = $clog2(REPLY_MAX + 1);
  localparam int unsigned MAX_ATTEMPTS = 3;
  localparam int unsigned ATTEMPT_W    = 2;
  localparam int unsigned WIN_W        = $clog2(2 * (REPLY_MAX / 8 + 1) + 1);

  // CRC-8, MSB first, initial value zero.
  localparam logic [7:0] CRC_POLY = 8'h07;

  // Stream widths.
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    IK_LOAD  = 2'd0,
    IK_START = 2'd1,
    IK_REPLY = 2'd2,
    IK_TICK  = 2'd3
  } in_kind_e;

  typedef enum logic [1:0] {
    OK_TX     = 2'd0,
    OK_REPLY  = 2'd1,
    OK_STATUS = 2'd2
  } out_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_CRCOUT
  } state_e;

  typedef struct packed {
    logic       clear;
    logic       load;
    logic [7:0] data;
  } crc_ctrl_t;

  typedef struct packed {
    logic [6:0] count;
    logic       success;
    logic [1:0] attempt;
    logic [5:0] index;
    logic [7:0] data;
  } out_payload_t;

endpackage

// ----- rtl/crc8cmd_crc.sv -----
`timescale 1ns / 1ps

module crc8cmd_crc (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  crc8cmd_pkg::crc_ctrl_t ctrl_i,
  output logic                   busy_o,
  output logic [7:0]             crc_o
);
  import crc8cmd_pkg::*;

  localparam int unsigned CNT_W = $clog2(8 + 1);

  logic [7:0]       crc_q, crc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // One bit of the register is shifted through the polynomial per cycle.
  always_comb begin
    crc_d = crc_q;
    cnt_d = cnt_q;
    if (ctrl_i.clear) begin
      crc_d = '0;
      cnt_d = '0;
    end else if (ctrl_i.load) begin
      crc_d = crc_q ^ ctrl_i.data;
      cnt_d = CNT_W'(8);
    end else if (cnt_q != '0) begin
      crc_d = {crc_q[6:0], 1'b0} ^ (crc_q[7] ? CRC_POLY : 8'h00);
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
      cnt_q <= '0;
    end else begin
      crc_q <= crc_d;
      cnt_q <= cnt_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign crc_o  = crc_q;

endmodule

// ----- rtl/crc8_command_transaction_retry.sv -----
`timescale 1ns / 1ps

// Framed command engine with CRC-8 and retry.
// Input stream: tuser carries the item kind (load frame byte, start, reply
// byte, millisecond tick), tlast marks the final frame byte, and tdata carries
// the byte, the write request and the expected reply length. Output stream:
// tuser carries the result kind (transmitted byte, accepted reply byte,
// status), tlast marks the final result caused by one input transfer.
// A reply byte or a status appears in the output register on the next cycle.
// A start transfer, and a retry raised by the tick that closes a window,
// sends the frame from a 16-entry buffer with a registered read port. The
// bit-serial CRC unit must finish one byte before the next is loaded, and a
// write frame ends with its CRC byte. No input transfer is taken while the
// frame is being sent.
// Reset clears all control state: idle, empty frame, no transaction open.
// Buffer contents are not reset; only bytes loaded into the current frame
// are ever sent. When the receiver stalls, the result holds in the output
// register and the engine waits; one new input transfer may be taken while a
// result waits, provided the receiver takes that result in the same cycle.

module crc8_command_transaction_retry (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Fields from bit 0 up: byte_value[7:0], write_request[8], reply_length[15:9].
  input  logic [crc8cmd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // Fields: kind[1:0].
  input  logic [1:0]                         s_axis_tuser,
  input  logic                               s_axis_tlast,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Fields from bit 0 up: out_byte[7:0], reply_index[13:8], attempt[15:14],
  // success[16], received_count[23:17].
  output logic [crc8cmd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // Fields: out_kind[1:0].
  output logic [1:0]                         m_axis_tuser,
  output logic                               m_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready
);
  import crc8cmd_pkg::*;

  // Transaction and frame state.
  state_e                state_q, state_d;
  logic [FRAME_LW-1:0]   flen_q, flen_d;
  logic                  closed_q, closed_d;
  logic                  wr_q, wr_d;
  logic [REPLY_W-1:0]    target_q, target_d;
  logic [ATTEMPT_W-1:0]  attempt_q, attempt_d;
  logic [WIN_W-1:0]      win_q, win_d;
  logic [REPLY_W-1:0]    recv_q, recv_d;
  logic                  busy_q, busy_d;
  logic [FRAME_AW-1:0]   idx_q, idx_d;

  // Frame buffer with one write and one registered read port.
  logic [7:0]            frame_mem [FRAME_DEPTH];
  logic [7:0]            rd_q;

  // Output register.
  logic                  out_valid_q, out_valid_d;
  out_kind_e             out_kind_q, out_kind_d;
  logic                  out_last_q, out_last_d;
  out_payload_t          out_pl_q, out_pl_d;

  // Input fields.
  in_kind_e              in_kind;
  logic [7:0]            in_byte;
  logic                  in_wr;
  logic [6:0]            in_rlen;

  // Decoded events.
  logic                  out_free, in_acc;
  logic                  do_load, do_start, do_reply, do_tick;
  logic                  win_end, do_retry, do_status, send_go;
  logic                  ld_fire, crc_fire, idx_last;
  logic [WIN_W-1:0]      win_dec;
  logic [FRAME_LW-1:0]   load_base;
  logic [7:0]            tx_byte;

  crc_ctrl_t             crc_ctrl;
  logic                  crc_busy;
  logic [7:0]            crc_val;

  assign in_kind = in_kind_e'(s_axis_tuser);
  assign in_byte = s_axis_tdata[7:0];
  assign in_wr   = s_axis_tdata[8];
  assign in_rlen = s_axis_tdata[15:9];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // The first frame byte of a write carries the write flag in its LSB.
  assign tx_byte  = rd_q | {7'd0, (idx_q == '0) && wr_q};
  assign idx_last = ({1'b0, idx_q} == (flen_q - FRAME_LW'(1)));

  // Event decode and register updates.
  always_comb begin
    do_load   = in_acc && (in_kind == IK_LOAD) && !busy_q;
    do_start  = in_acc && (in_kind == IK_START) && !busy_q && (flen_q != '0);
    do_reply  = in_acc && (in_kind == IK_REPLY) && busy_q && (recv_q < target_q);
    do_tick   = in_acc && (in_kind == IK_TICK) && busy_q;
    win_dec   = (win_q != '0) ? win_q - WIN_W'(1) : '0;
    win_end   = do_tick && (win_dec == '0);
    do_retry  = win_end && (recv_q != target_q) && (attempt_q < ATTEMPT_W'(MAX_ATTEMPTS));
    do_status = win_end && !do_retry;
    send_go   = do_start || do_retry;
    ld_fire   = (state_q == ST_LOAD) && out_free && !crc_busy;
    crc_fire  = (state_q == ST_CRCOUT) && out_free && !crc_busy;
    load_base = closed_q ? '0 : flen_q;

    flen_d    = flen_q;
    closed_d  = closed_q;
    wr_d      = wr_q;
    target_d  = target_q;
    attempt_d = attempt_q;
    win_d     = win_q;
    recv_d    = recv_q;
    busy_d    = busy_q;
    idx_d     = idx_q;

    if (do_load) begin
      flen_d   = load_base + FRAME_LW'(load_base < FRAME_LW'(FRAME_DEPTH));
      closed_d = s_axis_tlast;
    end

    if (do_start) begin
      wr_d      = in_wr;
      target_d  = (in_rlen > 7'(REPLY_MAX)) ? REPLY_W'(REPLY_MAX) : REPLY_W'(in_rlen);
      attempt_d = ATTEMPT_W'(1);
      busy_d    = 1'b1;
    end else if (do_retry) begin
      attempt_d = attempt_q + ATTEMPT_W'(1);
    end

    if (do_tick) begin
      win_d = win_dec;
    end
    if (do_reply) begin
      recv_d = recv_q + REPLY_W'(1);
    end
    if (do_status) begin
      busy_d = 1'b0;
    end

    // Each attempt reopens the window and restarts the reply count.
    if (send_go) begin
      win_d  = WIN_W'(((target_d >> 3) + REPLY_W'(1)) << 1);
      recv_d = '0;
      idx_d  = '0;
    end else if (ld_fire && !idx_last) begin
      idx_d = idx_q + FRAME_AW'(1);
    end

    crc_ctrl.clear = send_go;
    crc_ctrl.load  = ld_fire;
    crc_ctrl.data  = tx_byte;

    out_valid_d = out_valid_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    out_pl_d    = out_pl_q;
    if (ld_fire || crc_fire || do_reply || do_status) begin
      out_valid_d      = 1'b1;
      out_pl_d         = '0;
      out_pl_d.attempt = attempt_d;
      out_last_d       = 1'b1;
      if (ld_fire) begin
        out_kind_d    = OK_TX;
        out_pl_d.data = tx_byte;
        out_last_d    = idx_last && !wr_q;
      end else if (crc_fire) begin
        out_kind_d    = OK_TX;
        out_pl_d.data = crc_val;
      end else if (do_reply) begin
        out_kind_d     = OK_REPLY;
        out_pl_d.data  = in_byte;
        out_pl_d.index = recv_q[5:0];
      end else begin
        out_kind_d       = OK_STATUS;
        out_pl_d.success = (recv_q == target_q);
        out_pl_d.count   = 7'(recv_q);
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (send_go) state_d = ST_FETCH;
      end
      ST_FETCH: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (ld_fire) begin
          if (!idx_last)  state_d = ST_FETCH;
          else if (wr_q)  state_d = ST_CRCOUT;
          else            state_d = ST_IDLE;
        end
      end
      ST_CRCOUT: begin
        if (crc_fire) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      flen_q      <= '0;
      closed_q    <= 1'b0;
      wr_q        <= 1'b0;
      target_q    <= '0;
      attempt_q   <= '0;
      win_q       <= '0;
      recv_q      <= '0;
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      flen_q      <= flen_d;
      closed_q    <= closed_d;
      wr_q        <= wr_d;
      target_q    <= target_d;
      attempt_q   <= attempt_d;
      win_q       <= win_d;
      recv_q      <= recv_d;
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
    out_pl_q   <= out_pl_d;
  end

  always_ff @(posedge clk_i) begin
    if (do_load && (load_base < FRAME_LW'(FRAME_DEPTH))) begin
      frame_mem[load_base[FRAME_AW-1:0]] <= in_byte;
    end
    rd_q <= frame_mem[idx_q];
  end

  crc8cmd_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .busy_o (crc_busy),
    .crc_o  (crc_val)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = out_pl_q;

endmodule

// ----- rtl/crc8cmd_chk.sv -----
`timescale 1ns / 1ps

module crc8cmd_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic [crc8cmd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic [1:0]                         s_axis_tuser,
  input logic                               s_axis_tlast,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic [crc8cmd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]                         m_axis_tuser,
  input logic                               m_axis_tlast,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready
);
  import crc8cmd_pkg::*;

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // While a frame is only partly sent, no new input transfer is taken.
  a_no_input_mid_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == OK_TX) && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready in the middle of a frame");

  // Reply bytes and status are single results of their transfer.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != OK_TX) |-> m_axis_tlast)
    else $error("reply or status without tlast");

  // Every result belongs to an attempt numbered from one.
  a_attempt_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:14] != 2'd0))
    else $error("result with attempt zero");

endmodule

bind crc8_command_transaction_retry crc8cmd_chk u_crc8cmd_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .s_axis_tlast  (s_axis_tlast),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
